[src/vbt_pkg.sv]
// Beam timing tracker package: phase codes, strobe bit positions, state and
// request types, timing constants and reset values.
// No dependencies.
package vbt_pkg;

  localparam int LINE_CLOCKS      = 228;
  localparam int FRAME_LINES      = 262;
  localparam int SYNC_LINES       = 3;
  localparam int BLANK_END_LINE   = 40;
  localparam int VISIBLE_END_LINE = 232;
  localparam int HBLANK_CLOCKS    = 68;

  localparam logic [7:0] PLAYER_HBLANK_POS  = 8'(HBLANK_CLOCKS + 3);
  localparam logic [7:0] MISSILE_HBLANK_POS = 8'(HBLANK_CLOCKS + 2);

  localparam int PB_WSYNC = 0;
  localparam int PB_RESP0 = 1;
  localparam int PB_RESP1 = 2;
  localparam int PB_RESM0 = 3;
  localparam int PB_RESM1 = 4;
  localparam int PB_RESBL = 5;

  typedef enum logic [2:0] {
    PH_VSYNC    = 3'd0,
    PH_VBLANK   = 3'd1,
    PH_HBLANK   = 3'd2,
    PH_DRAW     = 3'd3,
    PH_OVERSCAN = 3'd4
  } phase_t;

  typedef struct packed {
    logic [8:0] column;
    logic [8:0] line;
    phase_t     phase;
    logic [7:0] player0;
    logic [7:0] player1;
    logic [7:0] missile0;
    logic [7:0] missile1;
    logic [5:0] pending;
  } beam_state_t;

  typedef struct packed {
    logic [5:0] cycles;
    logic       vsync;
    logic [5:0] strobes;
  } step_req_t;

  localparam beam_state_t RESET_STATE = '{
    column:   9'd0,
    line:     9'd0,
    phase:    PH_VSYNC,
    player0:  8'd120,
    player1:  8'd200,
    missile0: 8'd220,
    missile1: 8'd10,
    pending:  6'd0
  };

  function automatic phase_t phase_of_line(logic [9:0] ln);
    phase_t ph;
    if (ln >= 10'(VISIBLE_END_LINE)) begin
      ph = PH_OVERSCAN;
    end else if (ln >= 10'(BLANK_END_LINE)) begin
      ph = PH_HBLANK;
    end else if (ln >= 10'(SYNC_LINES)) begin
      ph = PH_VBLANK;
    end else begin
      ph = PH_VSYNC;
    end
    return ph;
  endfunction

endpackage

[src/vbt_in_reg.sv]
// Input register of the beam timing tracker: holds one request and its valid
// flag until the step logic takes it. Depends on vbt_pkg.
module vbt_in_reg
  import vbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  step_req_t in_req,
  input  logic      advance,
  output logic      req_valid,
  output step_req_t req
);

  logic load;

  assign in_stall = req_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req <= in_req;
    end
  end

endmodule

[src/vbt_step.sv]
// Step logic of the beam timing tracker: strobe priority, position latching,
// column advance and phase machine for one request. Depends on vbt_pkg.
module vbt_step
  import vbt_pkg::*;
(
  input  beam_state_t state,
  input  step_req_t   req,
  output beam_state_t state_next,
  output logic        draw
);

  beam_state_t mid;
  logic [5:0]  pend;
  logic [9:0]  wsync_line;
  logic [7:0]  cycles3;
  logic [8:0]  col_sum;
  logic [8:0]  col_wrapped;
  logic        wrap;
  logic [9:0]  ln1;
  logic        draw_wsync;

  function automatic logic [7:0] latch_pos(phase_t ph, logic [8:0] col,
                                           logic [7:0] old, logic [7:0] hb);
    logic [7:0] pos;
    case (ph)
      PH_DRAW:   pos = col[7:0];
      PH_HBLANK: pos = hb;
      default:   pos = old;
    endcase
    return pos;
  endfunction

  assign pend       = state.pending | req.strobes;
  assign wsync_line = {1'b0, state.line} + 10'd1;

  always_comb begin
    mid         = state;
    mid.pending = pend;
    draw_wsync  = 1'b0;
    if (req.vsync && (state.line > 9'(SYNC_LINES))) begin
      mid.column = 9'd0;
      mid.line   = 9'd0;
      mid.phase  = PH_VSYNC;
    end else if (pend[PB_WSYNC]) begin
      mid.pending[PB_WSYNC] = 1'b0;
      draw_wsync = (state.line >= 9'(BLANK_END_LINE)) &&
                   (state.line < 9'(VISIBLE_END_LINE));
      mid.column = 9'd0;
      if (wsync_line >= 10'(FRAME_LINES)) begin
        mid.line  = 9'd0;
        mid.phase = PH_VSYNC;
      end else begin
        mid.line  = wsync_line[8:0];
        mid.phase = phase_of_line(wsync_line);
      end
    end else if (pend[PB_RESP0]) begin
      mid.pending[PB_RESP0] = 1'b0;
      mid.player0 = latch_pos(state.phase, state.column, state.player0, PLAYER_HBLANK_POS);
    end else if (pend[PB_RESP1]) begin
      mid.pending[PB_RESP1] = 1'b0;
      mid.player1 = latch_pos(state.phase, state.column, state.player1, PLAYER_HBLANK_POS);
    end else if (pend[PB_RESM0]) begin
      mid.pending[PB_RESM0] = 1'b0;
      mid.missile0 = latch_pos(state.phase, state.column, state.missile0,
                               MISSILE_HBLANK_POS);
    end else if (pend[PB_RESM1]) begin
      mid.pending[PB_RESM1] = 1'b0;
      mid.missile1 = latch_pos(state.phase, state.column, state.missile1,
                               MISSILE_HBLANK_POS);
    end else if (pend[PB_RESBL]) begin
      mid.pending[PB_RESBL] = 1'b0;
    end
  end

  assign cycles3     = {1'b0, req.cycles, 1'b0} + {2'b00, req.cycles};
  assign col_sum     = mid.column + {1'b0, cycles3};
  assign wrap        = col_sum >= 9'(LINE_CLOCKS);
  assign col_wrapped = col_sum - 9'(LINE_CLOCKS);
  assign ln1         = {1'b0, mid.line} + 10'd1;

  always_comb begin
    state_next        = mid;
    state_next.column = col_sum;
    draw              = draw_wsync;
    case (mid.phase)
      PH_VSYNC: begin
        if (wrap) begin
          state_next.column = col_wrapped;
          state_next.line   = ln1[8:0];
          if (ln1 >= 10'(SYNC_LINES)) begin
            state_next.phase = PH_VBLANK;
          end
        end
      end
      PH_VBLANK: begin
        if (wrap) begin
          state_next.column = col_wrapped;
          state_next.line   = ln1[8:0];
          if (ln1 >= 10'(BLANK_END_LINE)) begin
            state_next.phase = PH_HBLANK;
          end
        end
      end
      PH_HBLANK: begin
        if (col_sum >= 9'(HBLANK_CLOCKS)) begin
          state_next.phase = PH_DRAW;
        end
      end
      PH_DRAW: begin
        draw = 1'b1;
        if (wrap) begin
          state_next.column = col_wrapped;
          state_next.line   = ln1[8:0];
          if (ln1 >= 10'(VISIBLE_END_LINE)) begin
            state_next.phase = PH_OVERSCAN;
            draw = 1'b0;
          end else begin
            state_next.phase = PH_HBLANK;
          end
        end
      end
      PH_OVERSCAN: begin
        if (wrap) begin
          state_next.column = col_wrapped;
          if (ln1 >= 10'(FRAME_LINES)) begin
            state_next.line  = 9'd0;
            state_next.phase = PH_VSYNC;
          end else begin
            state_next.line = ln1[8:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/video_beam_timing_tracker.sv]
// Beam timing tracker top level: input register, beam state, step logic and
// result register. Depends on vbt_pkg, vbt_in_reg and vbt_step.
//
// One request per emulated CPU instruction arrives on the in_ channel
// (in_valid / in_stall) with the cycle count, the vertical sync bit and the
// new strobes. One result per request leaves on the out_ channel
// (out_valid / out_stall): beam column, line and phase after the step, the
// four latched object columns and the draw_line flag.
// An accepted request is held in the input register; the step logic then
// updates the beam state and the result register together once the
// result register is free to advance.
// Throughput is one request per cycle while the receiver does not stall;
// the state update loop through the step logic sets that figure.
// While the receiver stalls, the result register holds its request, the
// beam state holds, and the input register accepts at most one more request
// before in_stall rises.
// Reset clears both valid flags, returns the beam to column 0, line 0 in
// the vsync phase, clears pending strobes and sets object columns to
// 120, 200, 220 and 10.
module video_beam_timing_tracker
  import vbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] cpu_cycles,
  input  logic       vsync_on,
  input  logic       wsync_strobe,
  input  logic       resp0_strobe,
  input  logic       resp1_strobe,
  input  logic       resm0_strobe,
  input  logic       resm1_strobe,
  input  logic       resbl_strobe,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] beam_column,
  output logic [8:0] beam_line,
  output logic [2:0] beam_phase,
  output logic [7:0] player0_column,
  output logic [7:0] player1_column,
  output logic [7:0] missile0_column,
  output logic [7:0] missile1_column,
  output logic       draw_line
);

  step_req_t   in_req;
  step_req_t   req;
  logic        req_valid;
  logic        advance;
  logic        step;
  beam_state_t state;
  beam_state_t state_next;
  logic        draw_next;

  assign in_req = '{
    cycles:  cpu_cycles,
    vsync:   vsync_on,
    strobes: {resbl_strobe, resm1_strobe, resm0_strobe,
              resp1_strobe, resp0_strobe, wsync_strobe}
  };

  assign advance = !out_valid || !out_stall;
  assign step    = req_valid && advance;

  vbt_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  vbt_step u_step (
    .state      (state),
    .req        (req),
    .state_next (state_next),
    .draw       (draw_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RESET_STATE;
    end else if (step) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      beam_column     <= state_next.column;
      beam_line       <= state_next.line;
      beam_phase      <= state_next.phase;
      player0_column  <= state_next.player0;
      player1_column  <= state_next.player1;
      missile0_column <= state_next.missile0;
      missile1_column <= state_next.missile1;
      draw_line       <= draw_next;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> req_valid)
    else $error("accepted request not held in input register");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(state))
    else $error("beam state changed without a step");

  a_step_shows: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("step did not produce a result");

endmodule

[bench/tb_video_beam_timing_tracker.sv]
// Testbench for video_beam_timing_tracker: directed and random instruction
// requests, beam state predicted by a scoreboard class and checked per result.
// Depends on vbt_pkg and the video_beam_timing_tracker RTL.
module tb_video_beam_timing_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import vbt_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int N_RANDOM    = 1200;
  localparam int QUIET_TAIL  = 150;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [8:0] column;
    logic [8:0] line;
    logic [2:0] phase;
    logic [7:0] player0;
    logic [7:0] player1;
    logic [7:0] missile0;
    logic [7:0] missile1;
    logic       draw;
  } beam_result_t;

  class beam_scoreboard;
    beam_state_t  st;
    beam_result_t expected_beams[$];
    int           failures;

    function new();
      st = RESET_STATE;
      failures = 0;
    endfunction

    function phase_t line_phase(logic [9:0] ln);
      if (ln >= VISIBLE_END_LINE) return PH_OVERSCAN;
      if (ln >= BLANK_END_LINE) return PH_HBLANK;
      if (ln >= SYNC_LINES) return PH_VBLANK;
      return PH_VSYNC;
    endfunction

    function logic [7:0] latched(logic [7:0] old, logic [7:0] hblank_pos);
      if (st.phase == PH_DRAW) return st.column[7:0];
      if (st.phase == PH_HBLANK) return hblank_pos;
      return old;
    endfunction

    function void note_step(step_req_t req);
      logic [9:0]   ln;
      logic [9:0]   col;
      logic         drawn;
      beam_result_t r;
      st.pending = st.pending | req.strobes;
      drawn = 1'b0;
      if (req.vsync && st.line > SYNC_LINES) begin
        st.column = '0;
        st.line = '0;
        st.phase = PH_VSYNC;
      end else if (st.pending[PB_WSYNC]) begin
        st.pending[PB_WSYNC] = 1'b0;
        drawn = (st.line >= BLANK_END_LINE) && (st.line < VISIBLE_END_LINE);
        ln = 10'(st.line) + 10'd1;
        st.column = '0;
        if (ln >= FRAME_LINES) begin
          ln = '0;
          st.phase = PH_VSYNC;
        end else begin
          st.phase = line_phase(ln);
        end
        st.line = ln[8:0];
      end else if (st.pending[PB_RESP0]) begin
        st.pending[PB_RESP0] = 1'b0;
        st.player0 = latched(st.player0, PLAYER_HBLANK_POS);
      end else if (st.pending[PB_RESP1]) begin
        st.pending[PB_RESP1] = 1'b0;
        st.player1 = latched(st.player1, PLAYER_HBLANK_POS);
      end else if (st.pending[PB_RESM0]) begin
        st.pending[PB_RESM0] = 1'b0;
        st.missile0 = latched(st.missile0, MISSILE_HBLANK_POS);
      end else if (st.pending[PB_RESM1]) begin
        st.pending[PB_RESM1] = 1'b0;
        st.missile1 = latched(st.missile1, MISSILE_HBLANK_POS);
      end else if (st.pending[PB_RESBL]) begin
        st.pending[PB_RESBL] = 1'b0;
      end

      col = 10'(st.column) + 10'(req.cycles) * 10'd3;
      st.column = col[8:0];
      ln = 10'(st.line);
      case (st.phase)
        PH_VSYNC: begin
          if (st.column >= LINE_CLOCKS) begin
            st.column = st.column - 9'(LINE_CLOCKS);
            ln = ln + 10'd1;
            if (ln >= SYNC_LINES) st.phase = PH_VBLANK;
          end
        end
        PH_VBLANK: begin
          if (st.column >= LINE_CLOCKS) begin
            st.column = st.column - 9'(LINE_CLOCKS);
            ln = ln + 10'd1;
            if (ln >= BLANK_END_LINE) st.phase = PH_HBLANK;
          end
        end
        PH_HBLANK: begin
          if (st.column >= HBLANK_CLOCKS) st.phase = PH_DRAW;
        end
        PH_DRAW: begin
          drawn = 1'b1;
          if (st.column >= LINE_CLOCKS) begin
            st.column = st.column - 9'(LINE_CLOCKS);
            ln = ln + 10'd1;
            if (ln >= VISIBLE_END_LINE) begin
              st.phase = PH_OVERSCAN;
              drawn = 1'b0;
            end else begin
              st.phase = PH_HBLANK;
            end
          end
        end
        PH_OVERSCAN: begin
          if (st.column >= LINE_CLOCKS) begin
            st.column = st.column - 9'(LINE_CLOCKS);
            ln = ln + 10'd1;
            if (ln >= FRAME_LINES) begin
              ln = '0;
              st.phase = PH_VSYNC;
            end
          end
        end
        default: ;
      endcase
      st.line = ln[8:0];

      r.column = st.column;
      r.line = st.line;
      r.phase = st.phase;
      r.player0 = st.player0;
      r.player1 = st.player1;
      r.missile0 = st.missile0;
      r.missile1 = st.missile1;
      r.draw = drawn;
      expected_beams.push_back(r);
    endfunction

    function void check_beam(beam_result_t got);
      beam_result_t exp_beam;
      if (expected_beams.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: no request waiting (col %0d line %0d)",
                   got.column, got.line);
        return;
      end
      exp_beam = expected_beams.pop_front();
      if (got !== exp_beam) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("beam mismatch: exp col %0d line %0d ph %0d p0 %0d p1 %0d m0 %0d m1 %0d dr %0d",
                   exp_beam.column, exp_beam.line, exp_beam.phase, exp_beam.player0,
                   exp_beam.player1, exp_beam.missile0, exp_beam.missile1, exp_beam.draw);
          $display("               got col %0d line %0d ph %0d p0 %0d p1 %0d m0 %0d m1 %0d dr %0d",
                   got.column, got.line, got.phase, got.player0,
                   got.player1, got.missile0, got.missile1, got.draw);
        end
      end
    endfunction

    function int waiting();
      return expected_beams.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  logic         out_valid;
  logic         out_stall;
  step_req_t    req_drv;
  beam_result_t beam_seen;
  logic         quiet;
  logic         hold_results;
  int           items_sent;

  beam_scoreboard sb = new();

  video_beam_timing_tracker dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cpu_cycles      (req_drv.cycles),
    .vsync_on        (req_drv.vsync),
    .wsync_strobe    (req_drv.strobes[PB_WSYNC]),
    .resp0_strobe    (req_drv.strobes[PB_RESP0]),
    .resp1_strobe    (req_drv.strobes[PB_RESP1]),
    .resm0_strobe    (req_drv.strobes[PB_RESM0]),
    .resm1_strobe    (req_drv.strobes[PB_RESM1]),
    .resbl_strobe    (req_drv.strobes[PB_RESBL]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .beam_column     (beam_seen.column),
    .beam_line       (beam_seen.line),
    .beam_phase      (beam_seen.phase),
    .player0_column  (beam_seen.player0),
    .player1_column  (beam_seen.player1),
    .missile0_column (beam_seen.missile0),
    .missile1_column (beam_seen.missile1),
    .draw_line       (beam_seen.draw)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_step(req_drv);
      if (out_valid && !out_stall) sb.check_beam(beam_seen);
    end
  end

  task automatic send_step(input logic [5:0] cyc, input logic vs, input logic [5:0] strobes);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_drv.cycles = cyc;
    req_drv.vsync = vs;
    req_drv.strobes = strobes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic random_step(input int kind);
    logic [5:0] s;
    logic       vs;
    int         wsync_den;
    int         vsync_den;
    case (kind)
      0:       begin wsync_den = 2;  vsync_den = 0;  end
      1:       begin wsync_den = 4;  vsync_den = 3;  end
      default: begin wsync_den = 12; vsync_den = 40; end
    endcase
    s = '0;
    s[PB_WSYNC] = ($urandom_range(0, wsync_den - 1) == 0);
    s[PB_RESP0] = ($urandom_range(0, 5) == 0);
    s[PB_RESP1] = ($urandom_range(0, 5) == 0);
    s[PB_RESM0] = ($urandom_range(0, 5) == 0);
    s[PB_RESM1] = ($urandom_range(0, 5) == 0);
    s[PB_RESBL] = ($urandom_range(0, 5) == 0);
    vs = (vsync_den != 0) && ($urandom_range(0, vsync_den - 1) == 0);
    send_step(6'($urandom_range(0, 63)), vs, s);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        hold_results = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("video_beam_timing_tracker test failed");
    $finish;
  end

  initial begin : stimulus
    int base;
    int kind;
    int run_len;
    bit held;
    bit drained;
    rst = 1'b1;
    in_valid = 1'b0;
    req_drv = '0;
    quiet = 1'b0;
    hold_results = 1'b0;
    items_sent = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // extremes, vsync too early in the frame, every strobe at once
    send_step(6'd0, 1'b0, '0);
    send_step(6'd63, 1'b0, '0);
    send_step(6'd63, 1'b1, '1);
    repeat (5) send_step(6'd0, 1'b0, '0);
    repeat (6) send_step(6'd63, 1'b0, '0);
    // vsync past the sync lines wins over a pending wsync
    send_step(6'd63, 1'b1, 6'(1 << PB_WSYNC));
    send_step(6'd1, 1'b0, '0);
    repeat (5) send_step(6'd20, 1'b0, 6'(1 << PB_WSYNC));
    send_step(6'd30, 1'b0, 6'(1 << PB_RESP1));
    send_step(6'd30, 1'b0, 6'(1 << PB_RESM0));
    send_step(6'd30, 1'b0, 6'(1 << PB_RESM1));
    send_step(6'd30, 1'b0, 6'(1 << PB_RESBL));

    base = items_sent;
    while (items_sent - base < N_RANDOM) begin
      kind = $urandom_range(0, 2);
      run_len = $urandom_range(40, 160);
      repeat (run_len) begin
        if (items_sent - base < N_RANDOM) begin
          if (!held && items_sent - base >= 400) begin
            hold_results = 1'b1;
            held = 1'b1;
          end
          if (!drained && items_sent - base >= 800) begin
            wait_for_results();
            drained = 1'b1;
          end
          quiet = (items_sent - base >= N_RANDOM - QUIET_TAIL);
          random_step(kind);
        end
      end
      // close a frame-like run with a few sync lines
      if (kind == 0)
        repeat (3) send_step(6'($urandom_range(0, 63)), 1'b1, 6'(1 << PB_WSYNC));
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.waiting() == 0) begin
      $display("video_beam_timing_tracker test passed");
    end else begin
      $display("video_beam_timing_tracker test failed");
    end
    $finish;
  end

endmodule
